@@ hw/rtl/twt_pkg.sv @@
// Shared types and constants of the timing wheel timer core.
package twt_pkg;

   localparam int REQ_W      = 2;
   localparam int ID_W       = 5;
   localparam int TIMEOUT_W  = 24;
   localparam int KIND_W     = 3;
   localparam int PERIOD_W   = 16;
   localparam int ROUNDS_W   = 17;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int DIV_STEPS  = TIMEOUT_W;
   localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

   localparam logic [REQ_W-1:0] REQ_ARM    = 2'd0;
   localparam logic [REQ_W-1:0] REQ_CANCEL = 2'd1;
   localparam logic [REQ_W-1:0] REQ_TICK   = 2'd2;

   localparam logic [KIND_W-1:0] KIND_ARMED     = 3'd0;
   localparam logic [KIND_W-1:0] KIND_REJECTED  = 3'd1;
   localparam logic [KIND_W-1:0] KIND_CANCELLED = 3'd2;
   localparam logic [KIND_W-1:0] KIND_EXPIRED   = 3'd3;
   localparam logic [KIND_W-1:0] KIND_IDLE_TICK = 3'd4;

   localparam logic [0:0] CSR_IDX_TICK_PERIOD = 1'b0;

   localparam logic [ROUNDS_W-1:0] ROUNDS_MAX = '1;

   typedef struct packed {
      logic                 start;
      logic [TIMEOUT_W-1:0] dividend;
      logic [PERIOD_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic                 done;
      logic [TIMEOUT_W-1:0] quotient;
   } div_rsp_type;

endpackage

@@ hw/rtl/twt_divider.sv @@
// Restoring radix-2 divider, one quotient bit per cycle.
module twt_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  twt_pkg::div_req_type div_req,
   output twt_pkg::div_rsp_type div_rsp
);
   import twt_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [PERIOD_W-1:0]  rem_ff, rem_in;
   logic [TIMEOUT_W-1:0] quo_ff, quo_in;
   logic [PERIOD_W-1:0]  dsr_ff, dsr_in;
   logic [PERIOD_W:0]    trial;
   logic                 fits;

   always_comb begin
      trial   = {rem_ff, quo_ff[TIMEOUT_W-1]};
      fits    = trial >= {1'b0, dsr_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = div_req.dividend;
         dsr_in  = div_req.divisor;
      end else if (busy_ff) begin
         rem_in = fits ? PERIOD_W'(trial - {1'b0, dsr_ff}) : trial[PERIOD_W-1:0];
         quo_in = {quo_ff[TIMEOUT_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

@@ hw/rtl/timing_wheel_timer_core.sv @@
// Timing wheel timer: top level with entry memory, scan sequencer and register port.
// Cancel and reject give their result in the cycle after the beat; the next beat can follow.
// Arm runs a 24-step divide by the tick period, then the DIV_SLOTS and ARM_WRITE states for slot and rounds.
// Tick scans every entry, one entry memory read per cycle, results as found.
// Results are a registered strobe of one cycle each; the receiver cannot stall them.
// Reset clears the sequencer, the active bits, current slot and tick_period (to 1).
module timing_wheel_timer_core #(
   parameter int NUM_SLOTS  = 64,
   parameter int NUM_TIMERS = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [twt_pkg::REQ_W-1:0]            req_type,
   input  logic [twt_pkg::ID_W-1:0]             req_timer_id,
   input  logic signed [twt_pkg::TIMEOUT_W-1:0] req_timeout_ms,
   output logic                                 rsp_strobe,
   output logic [twt_pkg::KIND_W-1:0]           rsp_kind,
   output logic [twt_pkg::ID_W-1:0]             rsp_expired_id,
   output logic                                 rsp_last,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [twt_pkg::CSR_ADDR_W-1:0]       paddr,
   input  logic [twt_pkg::CSR_DATA_W-1:0]       pwdata,
   output logic [twt_pkg::CSR_DATA_W-1:0]       prdata,
   output logic                                 pready
);
   import twt_pkg::*;

   localparam int SLOT_W = $clog2(NUM_SLOTS);
   localparam int IDX_W  = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam int WORD_W = SLOT_W + ROUNDS_W;

   // Ticks are split by a constant reciprocal that is exact for every 24-bit tick count.
   localparam int     SPLIT_SHIFT = TIMEOUT_W + SLOT_W;
   localparam int     RECIP_W     = TIMEOUT_W + 2;
   localparam int     PROD_W      = TIMEOUT_W + RECIP_W;
   localparam longint RECIP_VAL   = ((longint'(1) << SPLIT_SHIFT) + longint'(NUM_SLOTS)
                                     - longint'(1)) / longint'(NUM_SLOTS);
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_VAL);

   localparam logic [2:0] ST_IDLE      = 3'd0;
   localparam logic [2:0] ST_DIV_TICKS = 3'd1;
   localparam logic [2:0] ST_DIV_SLOTS = 3'd2;
   localparam logic [2:0] ST_SCAN      = 3'd3;
   localparam logic [2:0] ST_DRAIN     = 3'd4;
   localparam logic [2:0] ST_FINISH    = 3'd5;
   localparam logic [2:0] ST_ARM_WRITE = 3'd6;

   logic [2:0]            state_ff, state_in;
   logic [PERIOD_W-1:0]   period_ff, period_in;
   logic [SLOT_W-1:0]     cur_ff, cur_in;
   logic [NUM_TIMERS-1:0] active_ff, active_in;
   logic [IDX_W-1:0]      arm_idx_ff, arm_idx_in;
   logic [IDX_W-1:0]      rd_idx_ff, rd_idx_in;
   logic [IDX_W-1:0]      pidx_ff;
   logic                  pv_ff;
   logic                  pend_ff, pend_in;
   logic [ID_W-1:0]       pend_id_ff, pend_id_in;
   logic                  rsp_strobe_ff, rsp_strobe_in;
   logic [KIND_W-1:0]     rsp_kind_ff, rsp_kind_in;
   logic [ID_W-1:0]       rsp_id_ff, rsp_id_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic [TIMEOUT_W-1:0]  ticks_ff, ticks_in;
   logic [TIMEOUT_W-1:0]  split_quo_ff, split_quo_in;

   logic [WORD_W-1:0]     mem [NUM_TIMERS];
   logic [WORD_W-1:0]     rd_data_ff;
   logic                  mem_we;
   logic [IDX_W-1:0]      mem_waddr;
   logic [WORD_W-1:0]     mem_wdata;

   div_req_type           div_req;
   div_rsp_type           div_rsp;

   logic                  accept;
   logic                  csr_wr;
   logic [PERIOD_W-1:0]   period_eff;
   logic [TIMEOUT_W-1:0]  ticks;
   logic [PROD_W-1:0]     split_prod;
   logic [TIMEOUT_W-1:0]  split_back;
   logic [TIMEOUT_W-1:0]  split_rem;
   logic [ROUNDS_W-1:0]   rounds_sat;
   logic [SLOT_W:0]       slot_sum;
   logic [SLOT_W-1:0]     slot_new;
   logic [SLOT_W-1:0]     ent_slot;
   logic [ROUNDS_W-1:0]   ent_rounds;
   logic                  hit;

   twt_divider u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign accept     = start && !busy;
   assign csr_wr     = psel && penable && pwrite;
   assign period_eff = (period_ff == '0) ? PERIOD_W'(1) : period_ff;
   assign ticks      = (div_rsp.quotient == '0) ? TIMEOUT_W'(1) : div_rsp.quotient;
   assign split_prod = PROD_W'(ticks_ff) * PROD_W'(RECIP);
   assign split_back = split_quo_ff * TIMEOUT_W'(NUM_SLOTS);
   assign split_rem  = ticks_ff - split_back;
   assign rounds_sat = (split_quo_ff > TIMEOUT_W'(ROUNDS_MAX)) ? ROUNDS_MAX
                       : split_quo_ff[ROUNDS_W-1:0];
   // The remainder is below NUM_SLOTS, so one conditional subtract wraps the sum.
   assign slot_sum   = {1'b0, cur_ff} + {1'b0, SLOT_W'(split_rem)};
   assign slot_new   = (slot_sum >= (SLOT_W + 1)'(NUM_SLOTS))
                       ? SLOT_W'(slot_sum - (SLOT_W + 1)'(NUM_SLOTS)) : slot_sum[SLOT_W-1:0];
   assign ent_slot   = rd_data_ff[WORD_W-1:ROUNDS_W];
   assign ent_rounds = rd_data_ff[ROUNDS_W-1:0];
   assign hit        = pv_ff && active_ff[pidx_ff] && (ent_slot == cur_ff);

   always_comb begin
      state_in      = state_ff;
      period_in     = period_ff;
      cur_in        = cur_ff;
      active_in     = active_ff;
      arm_idx_in    = arm_idx_ff;
      rd_idx_in     = rd_idx_ff;
      pend_in       = pend_ff;
      pend_id_in    = pend_id_ff;
      rsp_strobe_in = 1'b0;
      rsp_kind_in   = rsp_kind_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_last_in   = rsp_last_ff;
      ticks_in      = ticks_ff;
      split_quo_in  = split_quo_ff;
      mem_we        = 1'b0;
      mem_waddr     = pidx_ff;
      mem_wdata     = {ent_slot, ent_rounds - 1'b1};
      div_req.start    = 1'b0;
      div_req.dividend = req_timeout_ms;
      div_req.divisor  = period_eff;

      if (csr_wr && paddr[2] == CSR_IDX_TICK_PERIOD) begin
         period_in = pwdata[PERIOD_W-1:0];
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_type)
                  REQ_ARM: begin
                     if (req_timeout_ms[TIMEOUT_W-1] || 32'(req_timer_id) >= NUM_TIMERS) begin
                        rsp_strobe_in = 1'b1;
                        rsp_kind_in   = KIND_REJECTED;
                        rsp_id_in     = '0;
                        rsp_last_in   = 1'b1;
                     end else begin
                        div_req.start = 1'b1;
                        arm_idx_in    = IDX_W'(req_timer_id);
                        state_in      = ST_DIV_TICKS;
                     end
                  end
                  REQ_CANCEL: begin
                     if (32'(req_timer_id) < NUM_TIMERS) begin
                        active_in[IDX_W'(req_timer_id)] = 1'b0;
                     end
                     rsp_strobe_in = 1'b1;
                     rsp_kind_in   = KIND_CANCELLED;
                     rsp_id_in     = '0;
                     rsp_last_in   = 1'b1;
                  end
                  REQ_TICK: begin
                     rd_idx_in = '0;
                     pend_in   = 1'b0;
                     state_in  = ST_SCAN;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_DIV_TICKS: begin
            if (div_rsp.done) begin
               ticks_in = ticks;
               state_in = ST_DIV_SLOTS;
            end
         end
         ST_DIV_SLOTS: begin
            split_quo_in = TIMEOUT_W'(split_prod[PROD_W-1:SPLIT_SHIFT]);
            state_in     = ST_ARM_WRITE;
         end
         ST_ARM_WRITE: begin
            mem_we                = 1'b1;
            mem_waddr             = arm_idx_ff;
            mem_wdata             = {slot_new, rounds_sat};
            active_in[arm_idx_ff] = 1'b1;
            rsp_strobe_in         = 1'b1;
            rsp_kind_in           = KIND_ARMED;
            rsp_id_in             = '0;
            rsp_last_in           = 1'b1;
            state_in              = ST_IDLE;
         end
         ST_SCAN: begin
            rd_idx_in = rd_idx_ff + 1'b1;
            if (rd_idx_ff == IDX_W'(NUM_TIMERS - 1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            rsp_strobe_in = 1'b1;
            rsp_last_in   = 1'b1;
            if (pend_ff) begin
               rsp_kind_in = KIND_EXPIRED;
               rsp_id_in   = pend_id_ff;
            end else begin
               rsp_kind_in = KIND_IDLE_TICK;
               rsp_id_in   = '0;
            end
            pend_in  = 1'b0;
            cur_in   = (cur_ff == SLOT_W'(NUM_SLOTS - 1)) ? '0 : cur_ff + 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // An expiry is held back one find so that the final one can carry last.
      if (hit) begin
         if (ent_rounds == '0) begin
            active_in[pidx_ff] = 1'b0;
            if (pend_ff) begin
               rsp_strobe_in = 1'b1;
               rsp_kind_in   = KIND_EXPIRED;
               rsp_id_in     = pend_id_ff;
               rsp_last_in   = 1'b0;
            end
            pend_in    = 1'b1;
            pend_id_in = ID_W'(pidx_ff);
         end else begin
            mem_we = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         period_ff     <= PERIOD_W'(1);
         cur_ff        <= '0;
         active_ff     <= '0;
         pv_ff         <= 1'b0;
         pend_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         period_ff     <= period_in;
         cur_ff        <= cur_in;
         active_ff     <= active_in;
         pv_ff         <= (state_ff == ST_SCAN);
         pend_ff       <= pend_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      arm_idx_ff   <= arm_idx_in;
      rd_idx_ff    <= rd_idx_in;
      pidx_ff      <= rd_idx_ff;
      pend_id_ff   <= pend_id_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_id_ff    <= rsp_id_in;
      rsp_last_ff  <= rsp_last_in;
      ticks_ff     <= ticks_in;
      split_quo_ff <= split_quo_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_idx_ff];
   end

   assign busy           = (state_ff != ST_IDLE);
   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_kind       = rsp_kind_ff;
   assign rsp_expired_id = rsp_id_ff;
   assign rsp_last       = rsp_last_ff;
   assign pready         = 1'b1;
   assign prdata         = (paddr[2] == CSR_IDX_TICK_PERIOD)
                           ? CSR_DATA_W'(period_ff) : '0;

endmodule

@@ test/timing_wheel_timer_core_tb.sv @@
// Self-checking testbench for the timing wheel timer core: arm, cancel, tick and tick period.
module timing_wheel_timer_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import twt_pkg::*;

   localparam int NUM_SLOTS    = 64;
   localparam int NUM_TIMERS   = 32;
   localparam int ITEMS_PER_PHASE = 46;
   localparam int DRAIN_CYCLES = 60;
   localparam int CYCLE_LIMIT  = 400000;
   localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [ID_W-1:0]   expired_id;
      logic              last;
   } timer_result_type;

   class timer_scoreboard_type;
      logic [PERIOD_W-1:0] tick_period;
      bit                  active [NUM_TIMERS];
      logic [5:0]          slot [NUM_TIMERS];
      logic [ROUNDS_W-1:0] rounds [NUM_TIMERS];
      int                  wheel_pos;
      timer_result_type    pending_results [$];
      int                  errors;

      function new();
         tick_period = 16'd1;
         wheel_pos = 0;
         errors = 0;
         foreach (active[i]) active[i] = 1'b0;
      endfunction

      task report_mismatch(input string msg);
         $display("mismatch: %s", msg);
         errors++;
      endtask

      // Works out the results one accepted beat will cause and updates the wheel state.
      function void note_request(input logic [REQ_W-1:0] req, input logic [ID_W-1:0] id,
                                 input logic [TIMEOUT_W-1:0] raw);
         int unsigned      period;
         int unsigned      ticks;
         int unsigned      round_cnt;
         int               n;
         timer_result_type res;
         timer_result_type fired [$];
         period = (tick_period == 0) ? 1 : tick_period;
         case (req)
            REQ_ARM: begin
               if (raw[TIMEOUT_W-1] || int'(id) >= NUM_TIMERS) begin
                  res = '{KIND_REJECTED, '0, 1'b1};
               end else begin
                  ticks = (raw < period) ? 1 : raw / period;
                  round_cnt = ticks / NUM_SLOTS;
                  if (round_cnt > ROUNDS_MAX) round_cnt = ROUNDS_MAX;
                  active[id] = 1'b1;
                  rounds[id] = round_cnt[ROUNDS_W-1:0];
                  slot[id] = 6'((wheel_pos + ticks % NUM_SLOTS) % NUM_SLOTS);
                  res = '{KIND_ARMED, '0, 1'b1};
               end
               pending_results.push_back(res);
            end
            REQ_CANCEL: begin
               if (int'(id) < NUM_TIMERS) active[id] = 1'b0;
               res = '{KIND_CANCELLED, '0, 1'b1};
               pending_results.push_back(res);
            end
            REQ_TICK: begin
               for (int i = 0; i < NUM_TIMERS; i++) begin
                  if (active[i] && int'(slot[i]) == wheel_pos) begin
                     if (rounds[i] == 0) begin
                        active[i] = 1'b0;
                        res = '{KIND_EXPIRED, ID_W'(i), 1'b0};
                        fired.push_back(res);
                     end else begin
                        rounds[i] = rounds[i] - 1'b1;
                     end
                  end
               end
               wheel_pos = (wheel_pos + 1) % NUM_SLOTS;
               n = fired.size();
               if (n == 0) begin
                  res = '{KIND_IDLE_TICK, '0, 1'b1};
                  pending_results.push_back(res);
               end else begin
                  fired[n-1].last = 1'b1;
                  foreach (fired[k]) pending_results.push_back(fired[k]);
               end
            end
            default: ;
         endcase
      endfunction

      task check_result(input logic [KIND_W-1:0] kind, input logic [ID_W-1:0] id,
                        input logic last);
         timer_result_type exp_res;
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result kind=%0d id=%0d last=%0d",
                                      kind, id, last));
         end else begin
            exp_res = pending_results.pop_front();
            if (kind !== exp_res.kind)
               report_mismatch($sformatf("kind %0d, expected %0d", kind, exp_res.kind));
            if (id !== exp_res.expired_id)
               report_mismatch($sformatf("expired_id %0d, expected %0d",
                                         id, exp_res.expired_id));
            if (last !== exp_res.last)
               report_mismatch($sformatf("last %0d, expected %0d", last, exp_res.last));
         end
      endtask
   endclass

   logic                        clock;
   logic                        reset;
   logic                        start;
   logic                        busy;
   logic [REQ_W-1:0]            req_type;
   logic [ID_W-1:0]             req_timer_id;
   logic signed [TIMEOUT_W-1:0] req_timeout_ms;
   logic                        rsp_strobe;
   logic [KIND_W-1:0]           rsp_kind;
   logic [ID_W-1:0]             rsp_expired_id;
   logic                        rsp_last;
   logic                        psel;
   logic                        penable;
   logic                        pwrite;
   logic [CSR_ADDR_W-1:0]       paddr;
   logic [CSR_DATA_W-1:0]       pwdata;
   logic [CSR_DATA_W-1:0]       prdata;
   logic                        pready;

   timer_scoreboard_type sb = new();
   int                   cycle_count = 0;
   bit                   burst_mode = 1'b0;

   timing_wheel_timer_core #(
      .NUM_SLOTS (NUM_SLOTS),
      .NUM_TIMERS(NUM_TIMERS)
   ) u_dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_type      (req_type),
      .req_timer_id  (req_timer_id),
      .req_timeout_ms(req_timeout_ms),
      .rsp_strobe    (rsp_strobe),
      .rsp_kind      (rsp_kind),
      .rsp_expired_id(rsp_expired_id),
      .rsp_last      (rsp_last),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe) sb.check_result(rsp_kind, rsp_expired_id, rsp_last);
   end

   // Leaves start high after the beat is taken, so back-to-back beats need no extra edge.
   task automatic send_request(input logic [REQ_W-1:0] req, input logic [ID_W-1:0] id,
                               input logic [TIMEOUT_W-1:0] timeout);
      int gap;
      gap = burst_mode ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start          <= 1'b1;
      req_type       <= req;
      req_timer_id   <= id;
      req_timeout_ms <= timeout;
      @(posedge clock);
      while (busy) @(posedge clock);
      sb.note_request(req, id, timeout);
   endtask

   task automatic drain();
      while (sb.pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_access(input logic write_en, input logic [PERIOD_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= write_en;
      paddr   <= {CSR_IDX_TICK_PERIOD, 2'b00};
      pwdata  <= {{(CSR_DATA_W-PERIOD_W){1'b0}}, value};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (write_en) begin
         sb.tick_period = value;
      end else if (prdata !== {{(CSR_DATA_W-PERIOD_W){1'b0}}, sb.tick_period}) begin
         sb.report_mismatch($sformatf("tick_period read 0x%0h, expected 0x%0h",
                                      prdata, sb.tick_period));
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic random_item(output bit counted);
      int unsigned         sel;
      int unsigned         eff;
      int unsigned         hi;
      logic [TIMEOUT_W-1:0] raw;
      logic [ID_W-1:0]      id;
      eff = (sb.tick_period == 0) ? 1 : sb.tick_period;
      id  = ID_W'($urandom());
      raw = TIMEOUT_W'($urandom());
      sel = $urandom_range(0, 99);
      counted = 1'b1;
      if (sel < 45) begin
         send_request(REQ_TICK, id, raw);
      end else if (sel < 80) begin
         sel = $urandom_range(0, 99);
         if (sel < 12) begin
            raw[TIMEOUT_W-1] = 1'b1;
         end else if (sel < 27) begin
            // keep the fully random value
         end else if (sel < 42) begin
            raw = TIMEOUT_W'($urandom_range(0, eff - 1));
         end else begin
            // Mostly within two wheel turns, so entries come back around and expire.
            hi = eff * 130;
            if (hi > 32'h7FFFFF) hi = 32'h7FFFFF;
            raw = TIMEOUT_W'($urandom_range(0, hi));
         end
         send_request(REQ_ARM, id, raw);
      end else if (sel < 95) begin
         send_request(REQ_CANCEL, id, raw);
      end else begin
         send_request(REQ_UNUSED, id, raw);
         counted = 1'b0;
      end
   endtask

   task automatic run_phase(input logic [PERIOD_W-1:0] period);
      int n;
      bit counted;
      csr_access(1'b1, period);
      csr_access(1'b0, '0);
      n = 0;
      while (n < ITEMS_PER_PHASE) begin
         if ((n % 16) == 0) burst_mode = ($urandom_range(0, 3) == 0);
         random_item(counted);
         if (counted) n++;
      end
      start <= 1'b0;
      drain();
   endtask

   initial begin
      reset          <= 1'b1;
      start          <= 1'b0;
      req_type       <= REQ_TICK;
      req_timer_id   <= '0;
      req_timeout_ms <= '0;
      psel           <= 1'b0;
      penable        <= 1'b0;
      pwrite         <= 1'b0;
      paddr          <= '0;
      pwdata         <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part at the reset tick period.
      csr_access(1'b0, '0);
      send_request(REQ_TICK, 5'd0, 24'd0);
      send_request(REQ_ARM, 5'd0, 24'd0);
      send_request(REQ_ARM, 5'd31, 24'd1);
      send_request(REQ_ARM, 5'd5, 24'h7FFFFF);
      send_request(REQ_ARM, 5'd6, 24'h800000);
      send_request(REQ_ARM, 5'd7, 24'hFFFFFF);
      send_request(REQ_ARM, 5'd3, 24'd64);
      send_request(REQ_ARM, 5'd0, 24'd2);
      send_request(REQ_CANCEL, 5'd31, 24'd0);
      send_request(REQ_CANCEL, 5'd20, 24'h555555);
      send_request(REQ_UNUSED, 5'd9, 24'hAAAAAA);
      send_request(REQ_ARM, 5'd12, 24'd1);
      send_request(REQ_ARM, 5'd10, 24'd1);
      send_request(REQ_ARM, 5'd11, 24'd1);
      burst_mode = 1'b1;
      // Several expiries in one tick, then the wheel walks on past the re-armed entry.
      repeat (6) send_request(REQ_TICK, 5'd31, 24'hFFFFFF);
      burst_mode = 1'b0;
      send_request(REQ_CANCEL, 5'd5, 24'd0);
      start <= 1'b0;
      drain();

      run_phase(16'd0);
      run_phase(16'hFFFF);
      run_phase(PERIOD_W'($urandom_range(2, 300)));
      run_phase(16'd1);
      run_phase(16'd7);

      if (sb.errors == 0 && sb.pending_results.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
